FILE: rtl/closest_point_on_segment_macros.svh
// assertion macros shared by the closest point on segment rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef CLOSEST_POINT_ON_SEGMENT_MACROS_SVH
`define CLOSEST_POINT_ON_SEGMENT_MACROS_SVH

// clocked check, off during reset
`define CPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked implication, off during reset
`define CPS_IMPLY(lbl, pre, post, msg) \
  `CPS_ASSERT(lbl, (pre) |-> (post), msg)

`endif

FILE: rtl/cps_pkg.sv
// package for closest point on segment: widths, register indexes, word types
// no dependencies
package cps_pkg;

  localparam int CW  = 32;
  localparam int FB  = 16;
  localparam int VW  = CW + 1;
  localparam int PW  = 2 * VW;
  localparam int DW  = PW + 2;
  localparam int QB  = CW + 1;
  localparam int WW  = DW + QB;
  localparam int PRW = CW + VW;
  localparam int PSW = PRW - FB;
  localparam int IDXW = 3;

  localparam logic [IDXW-1:0] CFG_START_X = 3'd0;
  localparam logic [IDXW-1:0] CFG_START_Y = 3'd1;
  localparam logic [IDXW-1:0] CFG_START_Z = 3'd2;
  localparam logic [IDXW-1:0] CFG_END_X   = 3'd3;
  localparam logic [IDXW-1:0] CFG_END_Y   = 3'd4;
  localparam logic [IDXW-1:0] CFG_END_Z   = 3'd5;
  localparam logic [IDXW-1:0] CFG_CLAMP   = 3'd6;

  typedef logic [CW-1:0] coord_t;
  typedef logic [VW-1:0] diff_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } in_word_t;

  typedef struct packed {
    coord_t param_t;
    coord_t closest_x;
    coord_t closest_y;
    coord_t closest_z;
    logic   degenerate;
    logic   saturated;
  } out_word_t;

  typedef struct packed {
    diff_t [2:0] v;
    logic        degen;
  } vec_word_t;

endpackage

FILE: rtl/cps_front.sv
// front stage: takes query words, forms P - A and flags a zero-length line
// depends on cps_pkg
module cps_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  cps_pkg::in_word_t      in_word_i,
  input  cps_pkg::coord_t [2:0]  start_i,
  input  cps_pkg::coord_t [2:0]  end_i,
  output logic                   vec_valid_o,
  input  logic                   vec_ready_i,
  output cps_pkg::vec_word_t     vec_word_o
);
  import cps_pkg::*;

  logic      valid_q, valid_d;
  vec_word_t word_q, word_d;
  coord_t [2:0] pt;

  assign pt = {in_word_i.point_x, in_word_i.point_y, in_word_i.point_z};
  assign in_ready_o = !valid_q || vec_ready_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      word_d.v[i] = $signed({pt[2-i][CW-1], pt[2-i]})
                  - $signed({start_i[i][CW-1], start_i[i]});
    end
    word_d.degen = (start_i == end_i);
    valid_d = in_valid_i || (valid_q && !vec_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= word_d;
    end
  end

  assign vec_valid_o = valid_q;
  assign vec_word_o  = word_q;

endmodule

FILE: rtl/cps_fifo.sv
// two-entry queue between front and back
// depends on cps_pkg
module cps_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               ready_o,
  input  cps_pkg::vec_word_t data_i,
  output logic               valid_o,
  input  logic               pop_i,
  output cps_pkg::vec_word_t data_o
);
  import cps_pkg::*;

  vec_word_t  mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/cps_back.sv
// back pipeline: dot products, pipelined restoring divide, clamp and result point
// depends on cps_pkg and closest_point_on_segment_macros.svh
module cps_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vec_valid_i,
  output logic                  vec_pop_o,
  input  cps_pkg::vec_word_t    vec_word_i,
  input  cps_pkg::coord_t [2:0] start_i,
  input  cps_pkg::coord_t [2:0] end_i,
  input  logic                  clamp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cps_pkg::out_word_t    out_word_o
);
  import cps_pkg::*;
  `include "closest_point_on_segment_macros.svh"

  localparam logic [QB-1:0]  ONE  = QB'(1) << FB;
  localparam logic [QB-1:0]  LNEG = QB'(1) << (CW - 1);
  localparam logic [QB-1:0]  LPOS = LNEG - QB'(1);
  localparam logic [PSW-1:0] CAP  = PSW'(1) << CW;
  localparam logic signed [CW+1:0] RMAX = {3'b000, {(CW-1){1'b1}}};
  localparam logic signed [CW+1:0] RMIN = {3'b111, {(CW-1){1'b0}}};

  logic en;
  diff_t [2:0] md;
  logic  [2:0] dneg;

  assign en = !out_valid_o || out_ready_i;
  assign vec_pop_o = en && vec_valid_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [VW-1:0] dd;
      dd = $signed({end_i[i][CW-1], end_i[i]}) - $signed({start_i[i][CW-1], start_i[i]});
      dneg[i] = dd[VW-1];
      md[i] = dd[VW-1] ? VW'(-dd) : VW'(dd);
    end
  end

  // stage 1: magnitudes and product signs
  logic s1_v, s1_deg;
  diff_t [2:0] s1_mv;
  logic  [2:0] s1_neg;
  // stage 2: products
  logic s2_v, s2_deg;
  logic [2:0][PW-1:0] s2_pd, s2_pv;
  logic [2:0] s2_neg;
  // stage 3: sums
  logic s3_v, s3_deg;
  logic [DW-1:0] s3_den, s3_pos, s3_neg;
  // divide chain
  logic [WW-1:0] dn_q [QB+1];
  logic [QB-1:0] dq_q [QB+1];
  logic [DW-1:0] dd_q [QB+1];
  logic dneg_q [QB+1];
  logic dovf_q [QB+1];
  logic ddeg_q [QB+1];
  logic dv_q   [QB+1];
  // stage 5: t
  logic s5_v, s5_deg, s5_tneg, s5_sat;
  logic [CW-1:0] s5_tmag, s5_tval;
  // stage 6: t times direction
  logic s6_v, s6_deg, s6_tneg, s6_sat;
  logic [CW-1:0] s6_tval;
  logic [2:0][PRW-1:0] s6_prod;
  // output
  logic      out_v_q;
  out_word_t out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      dv_q[0] <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v <= vec_valid_i;
      s2_v <= s1_v;
      s3_v <= s2_v;
      dv_q[0] <= s3_v;
      s5_v <= dv_q[QB];
      s6_v <= s5_v;
      out_v_q <= s6_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_deg <= vec_word_i.degen;
      for (int i = 0; i < 3; i++) begin
        s1_mv[i]  <= vec_word_i.v[i][VW-1] ? VW'(-$signed(vec_word_i.v[i])) : vec_word_i.v[i];
        s1_neg[i] <= dneg[i] ^ vec_word_i.v[i][VW-1];
      end
      s2_deg <= s1_deg;
      s2_neg <= s1_neg;
      for (int i = 0; i < 3; i++) begin
        s2_pd[i] <= md[i] * md[i];
        s2_pv[i] <= md[i] * s1_mv[i];
      end
      s3_deg <= s2_deg;
      s3_den <= DW'(s2_pd[0]) + DW'(s2_pd[1]) + DW'(s2_pd[2]);
      s3_pos <= (s2_neg[0] ? '0 : DW'(s2_pv[0])) + (s2_neg[1] ? '0 : DW'(s2_pv[1]))
              + (s2_neg[2] ? '0 : DW'(s2_pv[2]));
      s3_neg <= (s2_neg[0] ? DW'(s2_pv[0]) : '0) + (s2_neg[1] ? DW'(s2_pv[1]) : '0)
              + (s2_neg[2] ? DW'(s2_pv[2]) : '0);
      ddeg_q[0] <= s3_deg;
      dd_q[0]   <= s3_den;
      dneg_q[0] <= (s3_neg > s3_pos);
      dn_q[0]   <= WW'((s3_neg > s3_pos) ? s3_neg - s3_pos : s3_pos - s3_neg) << FB;
      dq_q[0]   <= '0;
      dovf_q[0] <= 1'b0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic [WW-1:0] dsh;
    logic          ge;
    assign dsh = WW'(dd_q[k]) << B;
    assign ge  = (dn_q[k] >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dn_q[k+1]   <= ge ? dn_q[k] - dsh : dn_q[k];
        dq_q[k+1]   <= dq_q[k] | (ge ? QB'(1) << B : '0);
        dd_q[k+1]   <= dd_q[k];
        dneg_q[k+1] <= dneg_q[k];
        ddeg_q[k+1] <= ddeg_q[k];
        if (k == 0) begin
          dovf_q[k+1] <= (dn_q[k] >= (WW'(dd_q[k]) << QB));
        end else begin
          dovf_q[k+1] <= dovf_q[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [QB-1:0] q, lim, tm;
      logic tn, st;
      q  = dovf_q[QB] ? '1 : dq_q[QB];
      st = 1'b0;
      if (clamp_i) begin
        tn = 1'b0;
        tm = dneg_q[QB] ? '0 : ((q > ONE) ? ONE : q);
      end else begin
        lim = dneg_q[QB] ? LNEG : LPOS;
        st  = (q > lim);
        tm  = st ? lim : q;
        tn  = dneg_q[QB];
      end
      if (tm == '0) begin
        tn = 1'b0;
      end
      s5_deg  <= ddeg_q[QB];
      s5_tneg <= tn;
      s5_sat  <= st;
      s5_tmag <= tm[CW-1:0];
      s5_tval <= tn ? CW'(-tm) : tm[CW-1:0];

      s6_deg  <= s5_deg;
      s6_tneg <= s5_tneg;
      s6_sat  <= s5_sat;
      s6_tval <= s5_tval;
      for (int i = 0; i < 3; i++) begin
        s6_prod[i] <= s5_tmag * md[i];
      end

      out_q <= out_d;
    end
  end

  always_comb begin
    coord_t [2:0] rc;
    logic st;
    st = s6_sat;
    for (int i = 0; i < 3; i++) begin
      logic [PSW-1:0] p;
      logic [CW:0] cp;
      logic signed [CW+1:0] off, r;
      p   = s6_prod[i][PRW-1:FB];
      cp  = (p > CAP) ? CAP[CW:0] : p[CW:0];
      off = (s6_tneg != dneg[i]) ? -$signed({1'b0, cp}) : $signed({1'b0, cp});
      r   = $signed({{2{start_i[i][CW-1]}}, start_i[i]}) + off;
      if (r > RMAX) begin
        r  = RMAX;
        st = 1'b1;
      end else if (r < RMIN) begin
        r  = RMIN;
        st = 1'b1;
      end
      rc[i] = r[CW-1:0];
    end
    if (s6_deg) begin
      out_d.param_t    = '0;
      out_d.closest_x  = start_i[0];
      out_d.closest_y  = start_i[1];
      out_d.closest_z  = start_i[2];
      out_d.degenerate = 1'b1;
      out_d.saturated  = 1'b0;
    end else begin
      out_d.param_t    = s6_tval;
      out_d.closest_x  = rc[0];
      out_d.closest_y  = rc[1];
      out_d.closest_z  = rc[2];
      out_d.degenerate = 1'b0;
      out_d.saturated  = st;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  `CPS_IMPLY(a_deg_t, out_valid_o && out_word_o.degenerate, (out_word_o.param_t == '0) && !out_word_o.saturated, "degenerate word with nonzero t or saturation")
  `CPS_IMPLY(a_deg_pt, out_valid_o && out_word_o.degenerate, out_word_o.closest_x == start_i[0], "degenerate word not at start point")
  `CPS_IMPLY(a_clamp, out_valid_o && clamp_i && !out_word_o.degenerate, !out_word_o.param_t[CW-1] && (out_word_o.param_t <= ONE[CW-1:0]), "clamped t outside 0..1")

endmodule

FILE: rtl/closest_point_on_segment.sv
// closest point on a 3d line or segment, signed q16.16, one word per cycle while
// the output is not stalled; path: front register, queue, 3 dot product stages,
// divide load register, 33 divide stages (one quotient bit each), t stage,
// product stage, output register; rate set by the fully pipelined divide chain
// async active-low reset empties the pipeline, start/end go to 0 and clamp mode to 1
module closest_point_on_segment (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cps_pkg::IDXW-1:0]    cfg_idx_i,
  input  logic [cps_pkg::CW-1:0]      cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  cps_pkg::in_word_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output cps_pkg::out_word_t          out_word_o
);
  import cps_pkg::*;

  coord_t [2:0] start_q, end_q;
  logic         clamp_q;
  logic         vec_valid, fifo_ready, fifo_valid, pop;
  vec_word_t    vec_word, fifo_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
      clamp_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_X: start_q[0] <= cfg_data_i;
        CFG_START_Y: start_q[1] <= cfg_data_i;
        CFG_START_Z: start_q[2] <= cfg_data_i;
        CFG_END_X:   end_q[0]   <= cfg_data_i;
        CFG_END_Y:   end_q[1]   <= cfg_data_i;
        CFG_END_Z:   end_q[2]   <= cfg_data_i;
        CFG_CLAMP:   clamp_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  cps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .start_i     (start_q),
    .end_i       (end_q),
    .vec_valid_o (vec_valid),
    .vec_ready_i (fifo_ready),
    .vec_word_o  (vec_word)
  );

  cps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (vec_valid),
    .ready_o (fifo_ready),
    .data_i  (vec_word),
    .valid_o (fifo_valid),
    .pop_i   (pop),
    .data_o  (fifo_word)
  );

  cps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vec_valid_i (fifo_valid),
    .vec_pop_o   (pop),
    .vec_word_i  (fifo_word),
    .start_i     (start_q),
    .end_i       (end_q),
    .clamp_i     (clamp_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
